@@ src/db4dwt_pkg.sv @@
// Shared constants and types for the db4 one-level wavelet analysis block.
package db4dwt_pkg;

    localparam int TAPS     = 8;
    localparam int DLEN     = TAPS - 1;
    localparam int SAMPLE_W = 24;
    localparam int OUT_W    = 25;
    localparam int COEF_W   = 16;
    localparam int QBITS    = 15;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = PROD_W + $clog2(TAPS);
    localparam int TDATA_W  = ((2 * OUT_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - 2 * OUT_W;

    // Number of coefficient pairs still due after the block's last sample,
    // minus one, for each parity of that sample's index.
    localparam logic [1:0] FLUSH_LEFT_EVEN = 2'd2;
    localparam logic [1:0] FLUSH_LEFT_ODD  = 2'd3;

    // db4 analysis filters in Q1.15.
    localparam logic signed [COEF_W-1:0] LOW_COEF [TAPS] = '{
        -16'sd347, 16'sd1078, 16'sd1011, -16'sd6129,
        -16'sd917, 16'sd20673, 16'sd23424, 16'sd7549
    };
    localparam logic signed [COEF_W-1:0] HIGH_COEF [TAPS] = '{
        -16'sd7549, 16'sd23424, -16'sd20673, -16'sd917,
        16'sd6129, 16'sd1011, -16'sd1078, -16'sd347
    };

    // One filter job: the eight-sample window, newest sample in entry 0.
    typedef struct packed {
        logic [TAPS-1:0][SAMPLE_W-1:0] win;
        logic                          final_pair;
    } job_t;

endpackage

@@ src/db4_dwt_analysis_level_core.sv @@
// Top level of the db4 one-level wavelet analysis block: sample sequencer and filter.
//
// One sample of a block enters per transfer on the s_ side and the block takes a
// new sample in every cycle in which s_tready is high. Each sample at an even index
// of its block yields one (approx, detail) pair of the full, zero-padded db4
// convolution; odd indices yield nothing. A sample marked with s_tlast closes the
// block: the sequencer then shifts zeros through the seven-sample delay line to
// produce the tail, issuing one pair per cycle, so s_tready is low after that
// transfer while the three (the last sample had an even index) or four (odd index)
// tail pairs enter the pipeline; a stalled output side stretches this. Every block
// end yields four pairs in total, and the last of them carries m_tlast. The next
// block starts from a cleared delay line at index zero. An input transfer reaches
// m_tvalid through three registers: a job register holding the eight-sample window,
// loaded at the transfer edge, a register of the sixteen constant products, and the
// output register holding the rounded sums. Ready passes back through the stages,
// so any stage may fill while m_tready is low.
module db4_dwt_analysis_level_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [db4dwt_pkg::SAMPLE_W-1:0]   s_tdata,  // [23:0] sample
    input  logic                              s_tlast,  // block_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [db4dwt_pkg::TDATA_W-1:0]    m_tdata,  // [24:0] approx, [49:25] detail, zeros
    output logic                              m_tlast   // final_pair
);
    import db4dwt_pkg::*;

    // Previous seven samples, newest in entry 0.
    logic [SAMPLE_W-1:0] dl_reg [DLEN];
    logic [SAMPLE_W-1:0] dl_next [DLEN];
    logic                parity_reg;
    logic                parity_next;
    logic                flush_active_reg;
    logic                flush_active_next;
    logic [1:0]          flush_left_reg;
    logic [1:0]          flush_left_next;

    logic                job_valid_reg;
    job_t                job_reg;
    job_t                job_next;
    logic                job_issue;
    logic                job_ready;
    logic                filt_ready;

    logic                accept;
    logic                flush_step;

    logic signed [OUT_W-1:0] approx;
    logic signed [OUT_W-1:0] detail;

    assign job_ready  = !job_valid_reg || filt_ready;
    assign s_tready   = !flush_active_reg && job_ready;
    assign accept     = s_tvalid && s_tready;
    assign flush_step = flush_active_reg && job_ready;

    // A pair is due for an even-index sample, and on every tail step: the tail
    // step skips the odd index by shifting in two zeros when needed.
    assign job_issue = (accept && !parity_reg) || flush_step;

    always_comb begin
        dl_next           = dl_reg;
        parity_next       = parity_reg;
        flush_active_next = flush_active_reg;
        flush_left_next   = flush_left_reg;
        job_next.final_pair = 1'b0;
        job_next.win        = '0;

        if (accept) begin
            job_next.win[0] = s_tdata;
            for (int i = 0; i < DLEN; i++) begin
                job_next.win[i+1] = dl_reg[i];
            end
            dl_next[0] = s_tdata;
            for (int i = 1; i < DLEN; i++) begin
                dl_next[i] = dl_reg[i-1];
            end
            parity_next = !parity_reg;
            if (s_tlast) begin
                flush_active_next = 1'b1;
                flush_left_next   = parity_reg ? FLUSH_LEFT_ODD : FLUSH_LEFT_EVEN;
            end
        end else if (flush_step) begin
            job_next.final_pair = (flush_left_reg == '0);
            if (parity_reg) begin
                // Odd index next: one zero goes by unused, the pair comes one later.
                for (int i = 0; i < DLEN - 1; i++) begin
                    job_next.win[i+2] = dl_reg[i];
                end
                for (int i = 2; i < DLEN; i++) begin
                    dl_next[i] = dl_reg[i-2];
                end
                dl_next[0] = '0;
                dl_next[1] = '0;
            end else begin
                for (int i = 0; i < DLEN; i++) begin
                    job_next.win[i+1] = dl_reg[i];
                end
                for (int i = 1; i < DLEN; i++) begin
                    dl_next[i] = dl_reg[i-1];
                end
                dl_next[0] = '0;
            end
            parity_next = 1'b1;
            if (flush_left_reg == '0) begin
                for (int i = 0; i < DLEN; i++) begin
                    dl_next[i] = '0;
                end
                parity_next       = 1'b0;
                flush_active_next = 1'b0;
            end else begin
                flush_left_next = flush_left_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DLEN; i++) begin
                dl_reg[i] <= '0;
            end
            parity_reg       <= 1'b0;
            flush_active_reg <= 1'b0;
            flush_left_reg   <= '0;
            job_valid_reg    <= 1'b0;
        end else begin
            dl_reg           <= dl_next;
            parity_reg       <= parity_next;
            flush_active_reg <= flush_active_next;
            flush_left_reg   <= flush_left_next;
            if (job_ready) begin
                job_valid_reg <= job_issue;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_ready && job_issue) begin
            job_reg <= job_next;
        end
    end

    db4dwt_filter u_filter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (job_valid_reg),
        .in_ready   (filt_ready),
        .in_job     (job_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_approx (approx),
        .out_detail (detail),
        .out_final  (m_tlast)
    );

    assign m_tdata = {{PAD_W{1'b0}}, detail, approx};

endmodule

@@ src/db4dwt_filter.sv @@
// Two-stage db4 low-pass and high-pass filter datapath with output register.
module db4dwt_filter (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  db4dwt_pkg::job_t                       in_job,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [db4dwt_pkg::OUT_W-1:0]    out_approx,
    output logic signed [db4dwt_pkg::OUT_W-1:0]    out_detail,
    output logic                                   out_final
);
    import db4dwt_pkg::*;

    logic signed [PROD_W-1:0] low_prod [TAPS];
    logic signed [PROD_W-1:0] high_prod [TAPS];
    logic signed [PROD_W-1:0] low_prod_reg [TAPS];
    logic signed [PROD_W-1:0] high_prod_reg [TAPS];
    logic                     prod_valid_reg;
    logic                     prod_final_reg;
    logic                     prod_ready;

    logic signed [ACC_W-1:0]  acc_low;
    logic signed [ACC_W-1:0]  acc_high;
    logic signed [OUT_W-1:0]  approx_next;
    logic signed [OUT_W-1:0]  detail_next;
    logic signed [OUT_W-1:0]  approx_reg;
    logic signed [OUT_W-1:0]  detail_reg;
    logic                     final_reg;
    logic                     out_valid_reg;
    logic                     out_free;

    // Round half up, then clamp to the signed output range.
    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] shifted;
        logic                    fits;
        begin
            shifted = (acc + ACC_W'(1 << (QBITS - 1))) >>> QBITS;
            fits = (shifted[ACC_W-1:OUT_W-1] == '0) || (shifted[ACC_W-1:OUT_W-1] == '1);
            if (fits) begin
                round_sat = shifted[OUT_W-1:0];
            end else if (shifted[ACC_W-1]) begin
                round_sat = {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
                round_sat = {1'b0, {(OUT_W-1){1'b1}}};
            end
        end
    endfunction

    assign out_free   = !out_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || out_free;
    assign in_ready   = prod_ready;

    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            low_prod[i]  = PROD_W'($signed(in_job.win[i])) * PROD_W'(LOW_COEF[i]);
            high_prod[i] = PROD_W'($signed(in_job.win[i])) * PROD_W'(HIGH_COEF[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (prod_ready) begin
            prod_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && in_valid) begin
            low_prod_reg   <= low_prod;
            high_prod_reg  <= high_prod;
            prod_final_reg <= in_job.final_pair;
        end
    end

    always_comb begin
        acc_low  = '0;
        acc_high = '0;
        for (int i = 0; i < TAPS; i++) begin
            acc_low  = acc_low + ACC_W'(low_prod_reg[i]);
            acc_high = acc_high + ACC_W'(high_prod_reg[i]);
        end
        approx_next = round_sat(acc_low);
        detail_next = round_sat(acc_high);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && prod_valid_reg) begin
            approx_reg <= approx_next;
            detail_reg <= detail_next;
            final_reg  <= prod_final_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_approx = approx_reg;
    assign out_detail = detail_reg;
    assign out_final  = final_reg;

endmodule

@@ src/db4dwt_checker.sv @@
// Port-level assertions for the db4 analysis block, bound to its top level.
module db4dwt_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tlast,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [db4dwt_pkg::TDATA_W-1:0]    m_tdata,
    input logic                              m_tlast
);
    import db4dwt_pkg::*;

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending right after reset");

    // The tail of a block is produced internally, so input is held off next cycle.
    a_flush_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken while the block tail is being flushed");

    // The padding above the two coefficients is always zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[TDATA_W-1:2*OUT_W] == '0))
        else $error("nonzero padding in result data");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind db4_dwt_analysis_level_core db4dwt_checker u_db4dwt_checker (.*);

@@ sim/db4_dwt_analysis_level_core_test.sv @@
// Self-checking testbench for the db4 one-level wavelet analysis core.
module db4_dwt_analysis_level_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W       = db4dwt_pkg::SAMPLE_W;
    localparam int OUT_W          = db4dwt_pkg::OUT_W;
    localparam int TDATA_W        = db4dwt_pkg::TDATA_W;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
    localparam int RANDOM_ITEMS   = 340;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int REPORT_LIMIT   = 10;

    // db4 analysis filters in Q1.15, tap 0 applies to the newest sample.
    localparam int LOWPASS_Q15 [8] = '{
        -347, 1078, 1011, -6129, -917, 20673, 23424, 7549
    };
    localparam int HIGHPASS_Q15 [8] = '{
        -7549, 23424, -20673, -917, 6129, 1011, -1078, -347
    };

    typedef struct packed {
        logic signed [OUT_W-1:0] approx;
        logic signed [OUT_W-1:0] detail;
        logic                    final_pair;
    } db4_pair_t;

    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SELDOM, RX_PERIODIC} rx_pattern_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tlast;

    // Predictor state: the previous seven samples and the index parity.
    logic signed [SAMPLE_W-1:0] db4_window [7];
    bit                         odd_index;
    db4_pair_t                  pending_pairs [$];

    int  fault_count = 0;
    int  items_sent  = 0;
    int  burst_left  = 0;
    bit  sender_gaps = 1'b1;
    bit  rx_hold_request = 1'b0;
    int  idle_cycles = 0;

    db4_pair_t got_pair;
    db4_pair_t want_pair;

    db4_dwt_analysis_level_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // One output of the full convolution at the current index: the exact sum of
    // products, rounded half up by adding 2^14 and flooring, then saturated.
    function automatic logic signed [OUT_W-1:0] db4_filter(
        input logic signed [SAMPLE_W-1:0] x, input bit highpass);
        longint acc;
        longint rounded;
        acc = longint'(x) * (highpass ? HIGHPASS_Q15[0] : LOWPASS_Q15[0]);
        for (int j = 0; j < 7; j++) begin
            acc += longint'(db4_window[j]) * (highpass ? HIGHPASS_Q15[j + 1]
                                                       : LOWPASS_Q15[j + 1]);
        end
        rounded = (acc + 64'sd16384) >>> 15;
        if (rounded > 64'sd16777215) rounded = 64'sd16777215;
        if (rounded < -64'sd16777216) rounded = -64'sd16777216;
        return rounded[OUT_W-1:0];
    endfunction

    // Emit a pair when the index is even, then shift the sample into the window.
    function automatic void db4_advance(input logic signed [SAMPLE_W-1:0] x);
        db4_pair_t pair;
        if (!odd_index) begin
            pair.approx     = db4_filter(x, 1'b0);
            pair.detail     = db4_filter(x, 1'b1);
            pair.final_pair = 1'b0;
            pending_pairs.push_back(pair);
        end
        for (int j = 6; j > 0; j--) begin
            db4_window[j] = db4_window[j - 1];
        end
        db4_window[0] = x;
        odd_index = ~odd_index;
    endfunction

    function automatic void db4_clear();
        foreach (db4_window[j]) db4_window[j] = '0;
        odd_index = 1'b0;
    endfunction

    // Expected pairs for one accepted sample. A block end flushes the tail with
    // zeros, which always leaves four pairs, and the last one is marked.
    function automatic void db4_predict(input logic signed [SAMPLE_W-1:0] x,
                                        input bit block_end);
        db4_advance(x);
        if (block_end) begin
            repeat (7) db4_advance('0);
            pending_pairs[pending_pairs.size() - 1].final_pair = 1'b1;
            db4_clear();
        end
    endfunction

    // Offer one sample and wait for its transfer. Valid stays high into the next
    // call unless the burst ends with sender_gaps set; the sender then idles a while.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value,
                               input bit block_end);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= block_end;
        do @(posedge aclk); while (!s_tready);
        db4_predict(value, block_end);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if (sender_gaps) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    endtask

    // Stop offering and wait until every expected pair has come out.
    task automatic wait_for_pending_pairs();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_pairs.size() != 0);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
            1:       return SAMPLE_W'($urandom_range(0, 400) - 200);
            2:       return '0;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic void note_mismatch(input string field, input int want,
                                          input int got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch in %s: expected %0d, got %0d",
                     $realtime, field, want, got);
        end
    endfunction

    // Result checker: every transfer on the m_ side is compared with the oldest
    // expected pair, field by field.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_pair.approx     = m_tdata[OUT_W-1:0];
            got_pair.detail     = m_tdata[2*OUT_W-1:OUT_W];
            got_pair.final_pair = m_tlast;
            if (pending_pairs.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT) begin
                    $display("%0t: unexpected pair approx %0d detail %0d last %0b",
                             $realtime, got_pair.approx, got_pair.detail,
                             got_pair.final_pair);
                end
            end else begin
                want_pair = pending_pairs.pop_front();
                if (got_pair.approx !== want_pair.approx)
                    note_mismatch("approx", int'(want_pair.approx),
                                  int'(got_pair.approx));
                if (got_pair.detail !== want_pair.detail)
                    note_mismatch("detail", int'(want_pair.detail),
                                  int'(got_pair.detail));
                if (got_pair.final_pair !== want_pair.final_pair)
                    note_mismatch("final_pair", int'(want_pair.final_pair),
                                  int'(got_pair.final_pair));
            end
        end
    end

    // Receiver: switches between stall patterns of its own, and on request holds
    // off for a long stretch so that the pipeline fills and stalls the input.
    initial begin
        rx_pattern_t pattern;
        int          pattern_left;
        int          phase;
        pattern      = RX_ALWAYS;
        pattern_left = 0;
        phase        = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_request) begin
                rx_hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            if (pattern_left == 0) begin
                pattern      = rx_pattern_t'($urandom_range(0, 3));
                pattern_left = $urandom_range(16, 96);
            end
            pattern_left--;
            case (pattern)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_MOSTLY: m_tready <= ($urandom_range(0, 9) < 7);
                RX_SELDOM: m_tready <= ($urandom_range(0, 9) < 3);
                default: begin
                    m_tready <= (phase == 0);
                    phase = (phase + 1) % 4;
                end
            endcase
        end
    end

    // Watchdog: too many cycles without a transfer on either side end the run.
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** db4_dwt_analysis_level_core: FAILED **");
        $finish;
    end

    // Blocks of one sample: the sample's own pair plus three tail pairs.
    task automatic test_single_sample_blocks();
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_W'(0), 1'b1);
        send_sample(SAMPLE_W'(1), 1'b1);
        send_sample(SAMPLE_W'(-1), 1'b1);
        wait_for_pending_pairs();
    endtask

    // Block ends at odd and even indices, with extreme values in the window.
    task automatic test_block_end_parity();
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        repeat (2) send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        for (int i = 0; i < 9; i++) begin
            send_sample((i % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN, i == 8);
        end
        for (int i = 0; i < 4; i++) begin
            send_sample(SAMPLE_W'(-1), i == 3);
        end
        wait_for_pending_pairs();
    endtask

    // Random blocks, mostly short with a few long ones, random sender bursts,
    // and now and then a pause until the output side has drained.
    task automatic test_random_blocks();
        int start_count;
        int block_len;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            block_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90)
                                                       : $urandom_range(1, 20);
            sender_gaps = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < block_len; i++) begin
                send_sample(pick_sample(), i == block_len - 1);
                if ($urandom_range(0, 60) == 0)
                    wait_for_pending_pairs();
            end
        end
        sender_gaps = 1'b1;
        wait_for_pending_pairs();
    endtask

    // The receiver holds off while the sender keeps offering without gaps, so
    // the pipeline fills up and back-pressure reaches the input.
    task automatic test_output_backpressure();
        sender_gaps     = 1'b0;
        rx_hold_request = 1'b1;
        for (int i = 0; i < 48; i++) begin
            send_sample(pick_sample(), i == 47);
        end
        sender_gaps = 1'b1;
        wait_for_pending_pairs();
    endtask

    initial begin
        db4_clear();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_single_sample_blocks();
        test_block_end_parity();
        test_output_backpressure();
        test_random_blocks();
        wait_for_pending_pairs();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_pairs.size() != 0)
            fault_count++;
        if (fault_count == 0)
            $display("** db4_dwt_analysis_level_core: PASSED **");
        else
            $display("** db4_dwt_analysis_level_core: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
src/db4dwt_pkg.sv
src/db4dwt_filter.sv
src/db4_dwt_analysis_level_core.sv
src/db4dwt_checker.sv
sim/db4_dwt_analysis_level_core_test.sv
